### design/cqp_pkg.sv
package cqp_pkg;

    // widths of the fixed fields on the ports
    localparam int unsigned FIELD_W     = 16;
    localparam int unsigned SHIFT_W     = 4;
    localparam int unsigned CFG_W       = 5;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned SUM_W       = FIELD_W + 2;
    // room for three bytes: at most 7 pending bits plus a 16-bit value
    localparam int unsigned ACC_PAD_W   = 3 * BYTE_W;
    localparam int unsigned HELD_W      = 3;
    localparam int unsigned HELD_SUM_W  = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROUND_SHIFT  = 2'd0,
        REG_MODULUS_BITS = 2'd1,
        REG_PACK_WIDTH   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] round_shift;
        logic [CFG_W-1:0]   modulus_bits;
        logic [CFG_W-1:0]   pack_width;
    } cfg_t;

endpackage

### design/cqp_quant.sv
module cqp_quant #(
    parameter int unsigned COEFF_WIDTH = 16
) (
    input  cqp_pkg::cfg_t                     cfg,
    input  logic [COEFF_WIDTH-1:0]            coefficient,
    input  logic [cqp_pkg::FIELD_W-1:0]       dither,
    output logic [COEFF_WIDTH-1:0]            value,
    output logic [cqp_pkg::CFG_W-1:0]         width
);

    localparam logic [cqp_pkg::CFG_W-1:0] MaxBits = cqp_pkg::CFG_W'(COEFF_WIDTH);

    logic [cqp_pkg::FIELD_W-1:0] half;
    logic [cqp_pkg::SUM_W-1:0]   sum;
    logic [cqp_pkg::SUM_W-1:0]   shifted;
    logic [cqp_pkg::CFG_W-1:0]   mod_eff;
    logic [cqp_pkg::CFG_W-1:0]   mask_bits;
    logic [COEFF_WIDTH-1:0]      mask;

    always_comb
    begin
        if (cfg.round_shift == '0)
        begin
            half = '0;
        end
        else
        begin
            half = cqp_pkg::FIELD_W'(1) << (cfg.round_shift - 1'b1);
        end
        sum     = cqp_pkg::SUM_W'(coefficient) + cqp_pkg::SUM_W'(dither)
                + cqp_pkg::SUM_W'(half);
        shifted = sum >> cfg.round_shift;

        // settings above the coefficient width count as the full width
        mod_eff = (cfg.modulus_bits > MaxBits) ? MaxBits : cfg.modulus_bits;
        width   = (cfg.pack_width > MaxBits) ? MaxBits : cfg.pack_width;

        mask_bits = (mod_eff < width) ? mod_eff : width;
        mask      = ~({COEFF_WIDTH{1'b1}} << mask_bits);
        value     = shifted[COEFF_WIDTH-1:0] & mask;
    end

endmodule

### design/coefficient_quantize_and_pack.sv
// coefficient quantizer and lsb-first bit packer
//
// input stream: s_tdata carries coefficient and dither, s_tlast marks the last
// coefficient of a polynomial. each coefficient is rounded, shifted by
// round_shift, masked to modulus_bits and pack_width, and appended to the bit
// stream. output stream: m_tdata carries one packed byte, m_tlast marks the
// last byte of the stream (the zero-padded flush byte when bits remain).
// config channel: cfg_index selects round_shift (0), modulus_bits (1) or
// pack_width (2); writes are taken every cycle, other indexes are dropped.
//
// the first byte of an item passes the input register and then the byte
// buffer before it is on m_tdata. the byte buffer drains one byte per cycle
// while m_tready is high, and takes the next item as it hands out the last
// byte of the current one. the next item enters the input register while
// bytes still drain.
// reset clears the bit accumulator, both buffers and the config registers
// (round_shift 0, modulus_bits 16, pack_width 16). when m_tready is low the
// byte buffer holds, the input register fills, then s_tready drops.
module coefficient_quantize_and_pack #(
    parameter int unsigned COEFF_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [2*cqp_pkg::FIELD_W-1:0]         s_tdata,   // coefficient, dither
    input  logic                                  s_tlast,   // final_item
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [cqp_pkg::BYTE_W-1:0]            m_tdata,   // packed_byte
    output logic                                  m_tlast,   // final_byte
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cqp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cqp_pkg::CFG_W-1:0]             cfg_data
);

    localparam int unsigned AccW = COEFF_WIDTH + 7;

    cqp_pkg::cfg_t cfg_reg;

    logic                                in_valid_reg;
    logic [COEFF_WIDTH-1:0]              in_coef_reg;
    logic [cqp_pkg::FIELD_W-1:0]         in_dither_reg;
    logic                                in_last_reg;

    logic [AccW-1:0]                     acc_reg;
    logic [AccW-1:0]                     acc_next;
    logic [cqp_pkg::HELD_W-1:0]          held_reg;
    logic [cqp_pkg::HELD_W-1:0]          held_next;

    logic [cqp_pkg::ACC_PAD_W-1:0]       buf_reg;
    logic [1:0]                          cnt_reg;
    logic                                buf_last_reg;

    logic [COEFF_WIDTH-1:0]              q_value;
    logic [cqp_pkg::CFG_W-1:0]           q_width;
    logic [AccW-1:0]                     acc_new;
    logic [cqp_pkg::ACC_PAD_W-1:0]       acc_pad;
    logic [cqp_pkg::HELD_SUM_W-1:0]      held_new;
    logic [1:0]                          n_full;
    logic                                flush;
    logic [1:0]                          n_bytes;
    logic                                pop;
    logic                                load;

    cqp_quant #(
        .COEFF_WIDTH(COEFF_WIDTH)
    ) u_quant (
        .cfg        (cfg_reg),
        .coefficient(in_coef_reg),
        .dither     (in_dither_reg),
        .value      (q_value),
        .width      (q_width)
    );

    assign cfg_ready = 1'b1;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = buf_reg[cqp_pkg::BYTE_W-1:0];
    assign m_tlast  = buf_last_reg && (cnt_reg == 2'd1);
    assign pop      = m_tvalid && m_tready;

    // byte buffer takes a new item when empty or handing out its last byte
    assign load     = in_valid_reg && ((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop));
    assign s_tready = !in_valid_reg || load;

    always_comb
    begin
        acc_new  = acc_reg | (AccW'(q_value) << held_reg);
        acc_pad  = cqp_pkg::ACC_PAD_W'(acc_new);
        held_new = cqp_pkg::HELD_SUM_W'(held_reg) + q_width;
        if (held_new[4])
        begin
            n_full = 2'd2;
        end
        else if (held_new[3])
        begin
            n_full = 2'd1;
        end
        else
        begin
            n_full = 2'd0;
        end
        // flush byte sits right after the full bytes
        flush   = in_last_reg && (held_new[2:0] != 3'd0);
        n_bytes = n_full + {1'b0, flush};

        if (in_last_reg)
        begin
            acc_next  = '0;
            held_next = '0;
        end
        else
        begin
            acc_next  = AccW'(acc_pad >> {n_full, 3'b000});
            held_next = held_new[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.round_shift  <= '0;
            cfg_reg.modulus_bits <= cqp_pkg::CFG_W'(16);
            cfg_reg.pack_width   <= cqp_pkg::CFG_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cqp_pkg::REG_ROUND_SHIFT:
                begin
                    cfg_reg.round_shift <= cfg_data[cqp_pkg::SHIFT_W-1:0];
                end
                cqp_pkg::REG_MODULUS_BITS:
                begin
                    cfg_reg.modulus_bits <= cfg_data;
                end
                cqp_pkg::REG_PACK_WIDTH:
                begin
                    cfg_reg.pack_width <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_coef_reg   <= s_tdata[COEFF_WIDTH-1:0];
            in_dither_reg <= s_tdata[2*cqp_pkg::FIELD_W-1:cqp_pkg::FIELD_W];
            in_last_reg   <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            held_reg     <= '0;
            cnt_reg      <= 2'd0;
            buf_last_reg <= 1'b0;
        end
        else if (load)
        begin
            acc_reg      <= acc_next;
            held_reg     <= held_next;
            cnt_reg      <= n_bytes;
            buf_last_reg <= in_last_reg;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= acc_pad;
        end
        else if (pop)
        begin
            buf_reg <= buf_reg >> cqp_pkg::BYTE_W;
        end
    end

    // a last item always leaves the accumulator empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && in_last_reg) |=> (held_reg == '0 && acc_reg == '0))
        else $error("accumulator not cleared after last item");

    // no stray bits above the pending count
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg >> held_reg) == '0)
        else $error("accumulator holds bits above the pending count");

    // bytes of one item leave without gaps in valid
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cnt_reg > 2'd1) |=> m_tvalid)
        else $error("byte buffer lost bytes of an item");

    // stream end only on the last byte of a buffered item
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && !in_last_reg) |=> !m_tlast)
        else $error("end of stream flagged on a non-final item");

endmodule

### tb/cqp_stream_checker.sv
module cqp_stream_checker #(
    parameter int unsigned COEFF_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [2*cqp_pkg::FIELD_W-1:0]         s_tdata,   // coefficient, dither
    input  logic                                  s_tlast,   // final_item
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [cqp_pkg::BYTE_W-1:0]            m_tdata,   // packed_byte
    input  logic                                  m_tlast,   // final_byte
    input  logic                                  cfg_valid,
    input  logic                                  cfg_ready,
    input  logic [cqp_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cqp_pkg::CFG_W-1:0]             cfg_data,
    output int                                    errors,
    output int                                    bytes_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [cqp_pkg::BYTE_W-1:0] data;
        logic                       last;
    } stream_byte_t;

    stream_byte_t   packed_bytes_due[$];
    cqp_pkg::cfg_t  regs;
    logic [31:0]    acc;
    logic [4:0]     held;

    // widths above the coefficient width count as the coefficient width
    function automatic logic [16:0] low_bits_mask(input int unsigned n);
        int unsigned k;
        k = (n > COEFF_WIDTH) ? COEFF_WIDTH : n;
        return (17'd1 << k) - 17'd1;
    endfunction

    task automatic quantize_and_pack(input logic [2*cqp_pkg::FIELD_W-1:0] item,
                                     input logic final_item);
        logic [15:0]  coef;
        logic [15:0]  dith;
        logic [17:0]  sum;
        logic [16:0]  q;
        int unsigned  shift;
        int unsigned  width;
        int           n;
        stream_byte_t out_bytes [3];
        begin
            coef  = 16'(item[15:0] & low_bits_mask(COEFF_WIDTH));
            dith  = item[31:16];
            shift = regs.round_shift;
            sum   = coef + dith + ((shift != 0) ? (18'd1 << (shift - 1)) : 18'd0);
            q     = 17'((sum >> shift) & low_bits_mask(regs.modulus_bits));
            width = (regs.pack_width > COEFF_WIDTH) ? COEFF_WIDTH : regs.pack_width;
            q     = q & low_bits_mask(width);
            acc   = acc | ({15'd0, q} << held[2:0]);
            held  = 5'(held[2:0] + width);
            n     = 0;
            while (held >= 5'd8)
            begin
                out_bytes[n].data = acc[7:0];
                out_bytes[n].last = 1'b0;
                n++;
                acc  = acc >> 8;
                held = held - 5'd8;
            end
            if (final_item)
            begin
                // leftover bits go out zero padded
                if (held != 0)
                begin
                    out_bytes[n].data = acc[7:0];
                    out_bytes[n].last = 1'b0;
                    n++;
                end
                if (n > 0)
                    out_bytes[n-1].last = 1'b1;
                acc  = '0;
                held = '0;
            end
            acc = acc & 32'h007F_FFFF;
            for (int i = 0; i < n; i++)
                packed_bytes_due.push_back(out_bytes[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.round_shift  = '0;
            regs.modulus_bits = 5'd16;
            regs.pack_width   = 5'd16;
            acc               = '0;
            held              = '0;
            packed_bytes_due.delete();
            errors            = 0;
            bytes_due         = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cqp_pkg::REG_ROUND_SHIFT:
                        regs.round_shift  = cfg_data[cqp_pkg::SHIFT_W-1:0];
                    cqp_pkg::REG_MODULUS_BITS:
                        regs.modulus_bits = cfg_data;
                    cqp_pkg::REG_PACK_WIDTH:
                        regs.pack_width   = cfg_data;
                    default:          ;
                endcase
            end
            if (s_tvalid && s_tready)
                quantize_and_pack(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (packed_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected byte: expected none, got data %02h last %0b",
                             $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    if (m_tdata !== packed_bytes_due[0].data)
                    begin
                        $display("%0t: packed byte mismatch: expected %02h, got %02h",
                                 $time, packed_bytes_due[0].data, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== packed_bytes_due[0].last)
                    begin
                        $display("%0t: final byte flag mismatch: expected %0b, got %0b",
                                 $time, packed_bytes_due[0].last, m_tlast);
                        errors++;
                    end
                    void'(packed_bytes_due.pop_front());
                end
            end
            bytes_due = packed_bytes_due.size();
        end
    end

endmodule

### tb/tb_coefficient_quantize_and_pack.sv
module tb_coefficient_quantize_and_pack;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COEFF_WIDTH  = 16;
    localparam int unsigned IDLE_LIMIT   = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned SETTLE_WAIT  = 4;
    // index with no register behind it
    localparam logic [cqp_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [2*cqp_pkg::FIELD_W-1:0]     s_tdata;   // coefficient, dither
    logic                              s_tlast;   // final_item
    logic                              m_tvalid;
    logic                              m_tready;
    logic [cqp_pkg::BYTE_W-1:0]        m_tdata;   // packed_byte
    logic                              m_tlast;   // final_byte
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [cqp_pkg::CFG_INDEX_W-1:0]   cfg_index;
    logic [cqp_pkg::CFG_W-1:0]         cfg_data;

    int                       errors;
    int                       bytes_due;
    int                       quiet_cycles;
    int                       stall_left;
    logic                     calm;

    coefficient_quantize_and_pack #(
        .COEFF_WIDTH(COEFF_WIDTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cqp_stream_checker #(
        .COEFF_WIDTH(COEFF_WIDTH)
    ) stream_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .bytes_due (bytes_due)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls in bursts of random length while calm is low
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [cqp_pkg::FIELD_W-1:0] pick_field();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return cqp_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    task automatic send_coefficient(input logic [cqp_pkg::FIELD_W-1:0] coef,
                                    input logic [cqp_pkg::FIELD_W-1:0] dith,
                                    input logic fin);
        begin
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            s_tdata  <= {dith, coef};
            s_tlast  <= fin;
            s_tvalid <= 1'b1;
            do @(posedge clk); while (!s_tready);
            @(negedge clk);
        end
    endtask

    // hold the sender until all bytes are out and the pipeline has gone quiet
    task automatic settle();
        begin
            s_tvalid <= 1'b0;
            while (bytes_due != 0) @(negedge clk);
            repeat (SETTLE_WAIT) @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [cqp_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [cqp_pkg::CFG_W-1:0] value);
        begin
            cfg_index <= index;
            cfg_data  <= value;
            cfg_valid <= 1'b1;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
        end
    endtask

    task automatic apply_settings(input logic [cqp_pkg::CFG_W-1:0] shift,
                                  input logic [cqp_pkg::CFG_W-1:0] modbits,
                                  input logic [cqp_pkg::CFG_W-1:0] packw);
        begin
            settle();
            write_register(cqp_pkg::REG_ROUND_SHIFT, shift);
            write_register(cqp_pkg::REG_MODULUS_BITS, modbits);
            write_register(cqp_pkg::REG_PACK_WIDTH, packw);
            cfg_valid <= 1'b0;
        end
    endtask

    initial
    begin
        int unsigned shift_sel;
        int unsigned mod_sel;
        int unsigned pack_sel;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        m_tready   = 1'b0;
        stall_left = 0;
        calm       = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: no shift, full modulus, 16-bit packing
        send_coefficient(16'h0000, 16'h0000, 1'b0);
        send_coefficient(16'hFFFF, 16'hFFFF, 1'b0);
        send_coefficient(16'hA5A5, 16'h5A5A, 1'b1);
        // largest shift, oversized modulus and pack width
        apply_settings(5'd15, 5'd31, 5'd31);
        send_coefficient(16'hFFFF, 16'hFFFF, 1'b1);
        // modulus of zero bits quantizes everything to zero
        apply_settings(5'd1, 5'd0, 5'd5);
        send_coefficient(16'h1234, 16'h4321, 1'b0);
        send_coefficient(16'hFFFF, 16'h0001, 1'b1);
        // nothing packed, final item gives no byte at all
        apply_settings(5'd0, 5'd16, 5'd0);
        send_coefficient(16'hFFFF, 16'hFFFF, 1'b0);
        send_coefficient(16'h0001, 16'h0002, 1'b1);
        // one full byte on a final item, no flush byte
        apply_settings(5'd4, 5'd12, 5'd8);
        send_coefficient(16'h0FF8, 16'h0007, 1'b1);
        apply_settings(5'd0, 5'd1, 5'd1);
        send_coefficient(16'h0001, 16'h0000, 1'b0);
        send_coefficient(16'h0000, 16'h0000, 1'b0);
        send_coefficient(16'h0003, 16'h0000, 1'b1);
        apply_settings(5'd2, 5'd16, 5'd12);
        send_coefficient(16'hFFFF, 16'h0000, 1'b0);
        send_coefficient(16'h8000, 16'h8000, 1'b1);
        // seven bits left pending, then a 16-bit item: two full bytes plus flush
        apply_settings(5'd0, 5'd16, 5'd7);
        send_coefficient(16'h007F, 16'h0000, 1'b0);
        settle();
        write_register(REG_SPARE, 5'h1F);
        write_register(cqp_pkg::REG_PACK_WIDTH, 5'd16);
        cfg_valid <= 1'b0;
        send_coefficient(16'hFFFF, 16'h0000, 1'b1);

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 7)
                calm = 1'b1;
            shift_sel = $urandom_range(0, 15);
            mod_sel   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            pack_sel  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
            if (phase == 0)
            begin
                shift_sel = 15;
                mod_sel   = 1;
                pack_sel  = 1;
            end
            else if (phase == 1)
            begin
                shift_sel = 0;
                mod_sel   = 16;
                pack_sel  = 16;
            end
            apply_settings(cqp_pkg::CFG_W'(shift_sel), cqp_pkg::CFG_W'(mod_sel),
                           cqp_pkg::CFG_W'(pack_sel));
            for (int k = 0; k < 22; k++)
            begin
                send_coefficient(pick_field(), pick_field(), ($urandom_range(0, 7) == 0) || k == 21);
                if (phase == 3 && k == 10)
                    settle();
            end
        end

        s_tvalid <= 1'b0;
        while (bytes_due != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
design/cqp_pkg.sv
design/cqp_quant.sv
design/coefficient_quantize_and_pack.sv
tb/cqp_stream_checker.sv
tb/tb_coefficient_quantize_and_pack.sv
